[src/smpq_pkg.sv]
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and constants of the stable min priority queue: entry layout,
// request and status codes, and the command broadcast along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package smpq_pkg;

  // default number of slots in the chain
  localparam int unsigned DEFAULT_DEPTH = 16;

  // payload widths
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned KEY_W  = 16;
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned STAT_W = 3;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_POP    = 2'd1,
    REQ_LIST   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STATUS_INSERTED = 3'd0,
    STATUS_POPPED   = 3'd1,
    STATUS_EMPTY    = 3'd2,
    STATUS_FULL     = 3'd3,
    STATUS_LISTED   = 3'd4
  } status_e;

  // operation applied by every cell at once
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_SHIFT  = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_e;

  // one stored entry
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [KEY_W-1:0] key;
  } entry_t;

  // command broadcast to the chain
  typedef struct packed {
    cell_op_e op;
    entry_t   ent;
  } cell_cmd_t;

endpackage

`default_nettype wire

[src/smpq_if.sv]
// ----------------------------------------------------------------------------
// smpq_if
// Valid/ready channels of the queue: the request channel and the result
// channel, each with a source and a sink modport.
// ----------------------------------------------------------------------------
`default_nettype none

interface smpq_req_if;
  import smpq_pkg::*;

  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [TAG_W-1:0] entry_tag;
  logic [KEY_W-1:0] entry_key;

  modport source (output valid, output req_type, output entry_tag, output entry_key,
                  input ready);
  modport sink   (input valid, input req_type, input entry_tag, input entry_key,
                  output ready);
endinterface

interface smpq_rsp_if;
  import smpq_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [TAG_W-1:0]  out_tag;
  logic [KEY_W-1:0]  out_key;
  logic              last;

  modport source (output valid, output status, output out_tag, output out_key,
                  output last, input ready);
  modport sink   (input valid, input status, input out_tag, input out_key,
                  input last, output ready);
endinterface

`default_nettype wire

[src/smpq_cell.sv]
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted chain. Compares its key against an incoming entry
// and takes its next content from the left neighbor, the right neighbor,
// the head or the broadcast entry.
// ----------------------------------------------------------------------------
`default_nettype none

module smpq_cell (
  input  logic               clk_i,
  input  smpq_pkg::cell_cmd_t cmd_i,
  input  logic               occupied_i,
  input  logic               at_end_i,
  input  logic               is_tail_i,
  input  logic               left_gt_i,
  input  smpq_pkg::entry_t   left_i,
  input  smpq_pkg::entry_t   right_i,
  input  smpq_pkg::entry_t   head_i,
  output logic               gt_o,
  output smpq_pkg::entry_t   ent_o
);
  import smpq_pkg::*;

  entry_t ent_q, ent_d;

  // strictly greater keeps equal keys ahead of the new entry
  assign gt_o  = occupied_i && (ent_q.key > cmd_i.ent.key);
  assign ent_o = ent_q;

  // next slot content
  always_comb begin
    ent_d = ent_q;
    case (cmd_i.op)
      OP_INSERT: begin
        if (left_gt_i) begin
          ent_d = left_i;
        end else if (gt_o || at_end_i) begin
          ent_d = cmd_i.ent;
        end
      end
      OP_SHIFT:  ent_d = right_i;
      OP_ROTATE: ent_d = is_tail_i ? head_i : right_i;
      default:   ent_d = ent_q;
    endcase
  end

  // slot storage, no reset on payload
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

`default_nettype wire

[src/smpq_chain.sv]
// ----------------------------------------------------------------------------
// smpq_chain
// Row of slot cells plus the fill count. Insert, pop and rotate each update
// every cell at once; the head entry is always visible at cell zero.
// ----------------------------------------------------------------------------
`default_nettype none

module smpq_chain #(
  parameter int unsigned QUEUE_DEPTH = smpq_pkg::DEFAULT_DEPTH,
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smpq_pkg::cell_cmd_t cmd_i,
  output logic [CW-1:0]       count_o,
  output smpq_pkg::entry_t    head_o
);
  import smpq_pkg::*;

  logic [CW-1:0]          count_q, count_d;
  entry_t                 ent_w [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] gt_w;

  assign count_o = count_q;
  assign head_o  = ent_w[0];

  // fill count follows insert and pop
  always_comb begin
    count_d = count_q;
    case (cmd_i.op)
      OP_INSERT: count_d = count_q + CW'(1);
      OP_SHIFT:  count_d = count_q - CW'(1);
      default:   count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // cell row
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] Idx = CW'(i);
    logic   left_gt;
    entry_t left_ent;
    entry_t right_ent;

    if (i == 0) begin : g_first
      assign left_gt  = 1'b0;
      assign left_ent = '0;
    end else begin : g_inner
      assign left_gt  = gt_w[i-1];
      assign left_ent = ent_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_ent = ent_w[i];
    end else begin : g_mid
      assign right_ent = ent_w[i+1];
    end

    smpq_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd_i),
      .occupied_i (Idx < count_q),
      .at_end_i   (Idx == count_q),
      .is_tail_i  ((Idx + CW'(1)) == count_q),
      .left_gt_i  (left_gt),
      .left_i     (left_ent),
      .right_i    (right_ent),
      .head_i     (ent_w[0]),
      .gt_o       (gt_w[i]),
      .ent_o      (ent_w[i])
    );
  end

endmodule

`default_nettype wire

[src/stable_min_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// stable_min_priority_queue_top
// Bounded priority queue sorted by ascending key, equal keys in arrival
// order. Insert, pop and list requests; results leave through an output
// register.
//
//   channel  modport  direction  payload
//   req_i    sink     in         req_type, entry_tag, entry_key
//   rsp_o    source   out        status, out_tag, out_key, last
//
// Insert and pop act on the whole chain at once: every cell compares and shifts.
// A list emits the stored entries in order; the chain rotates through cell
// zero and is back in place after the last entry leaves.
// Reset clears the fill count, the state and the result valid; slots hold
// whatever they had. A stalled result register holds the queue and the list.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_min_priority_queue_top #(
  parameter int unsigned QUEUE_DEPTH = smpq_pkg::DEFAULT_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  smpq_req_if.sink    req_i,
  smpq_rsp_if.source  rsp_o
);
  import smpq_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    idx_q, idx_d, idx_cur;
  logic [CW-1:0]    count;
  entry_t           head;
  cell_cmd_t        cmd;
  logic             out_free, accept, list_step, full, empty;
  logic             out_valid_q, out_valid_d, load_out;
  status_e          status_q, status_d;
  entry_t           out_ent_q, out_ent_d;
  logic             last_q, last_d;

  smpq_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .count_o (count),
    .head_o  (head)
  );

  // handshake
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && out_free;
  assign accept      = req_i.valid && req_i.ready;
  assign full        = (count == CW'(QUEUE_DEPTH));
  assign empty       = (count == '0);

  // request decode and list sequencing
  always_comb begin
    cmd.op      = OP_HOLD;
    cmd.ent.tag = req_i.entry_tag;
    cmd.ent.key = req_i.entry_key;
    state_d     = state_q;
    idx_d       = idx_q;
    idx_cur     = idx_q;
    list_step   = 1'b0;
    load_out    = 1'b0;
    status_d    = status_q;
    out_ent_d   = '0;
    last_d      = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_e'(req_i.req_type))
            REQ_INSERT: begin
              load_out = 1'b1;
              if (full) begin
                status_d = STATUS_FULL;
              end else begin
                cmd.op   = OP_INSERT;
                status_d = STATUS_INSERTED;
              end
            end
            REQ_POP: begin
              load_out = 1'b1;
              if (empty) begin
                status_d = STATUS_EMPTY;
              end else begin
                cmd.op    = OP_SHIFT;
                status_d  = STATUS_POPPED;
                out_ent_d = head;
              end
            end
            REQ_LIST: begin
              if (empty) begin
                load_out = 1'b1;
                status_d = STATUS_EMPTY;
              end else begin
                list_step = 1'b1;
                idx_cur   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_LIST: begin
        list_step = out_free;
      end
      default: state_d = S_IDLE;
    endcase

    // emit the head and rotate the chain by one slot
    if (list_step) begin
      cmd.op    = OP_ROTATE;
      load_out  = 1'b1;
      status_d  = STATUS_LISTED;
      out_ent_d = head;
      last_d    = ((idx_cur + CW'(1)) == count);
      idx_d     = idx_cur + CW'(1);
      state_d   = last_d ? S_IDLE : S_LIST;
    end
  end

  // result valid
  assign out_valid_d = load_out || (out_valid_q && !rsp_o.ready);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_q  <= status_d;
      out_ent_q <= out_ent_d;
      last_q    <= last_d;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.status  = status_q;
  assign rsp_o.out_tag = out_ent_q.tag;
  assign rsp_o.out_key = out_ent_q.key;
  assign rsp_o.last    = last_q;

`ifndef ASSERT_OFF
  // fill count never passes the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CW'(QUEUE_DEPTH))
    else $error("fill count beyond queue depth");

  // no new request while a list is streaming
  a_list_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST) |-> !req_i.ready)
    else $error("request taken during list");

  // an accepted insert into a non-full queue grows it by one
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_e'(req_i.req_type) == REQ_INSERT) && !full)
      |=> (count == ($past(count) + CW'(1))))
    else $error("insert did not grow the queue");

  // an accepted pop of a non-empty queue shrinks it by one
  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_e'(req_i.req_type) == REQ_POP) && !empty)
      |=> (count == ($past(count) - CW'(1))))
    else $error("pop did not shrink the queue");
`endif

endmodule

`default_nettype wire

[tb/tb_stable_min_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// tb_stable_min_priority_queue_top
// Self-checking bench for the stable min priority queue. A behavioral model
// of the sorted slot list predicts every result of each accepted request:
// directed runs on the empty queue, stable ordering of equal keys, and the
// full queue, then random insert/pop/list traffic. A checker compares each
// result with the oldest prediction; both channels stall at random but in the last test.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stable_min_priority_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  import smpq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = DEFAULT_DEPTH;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 20;

  // one predicted result
  typedef struct packed {
    status_e          status;
    logic [TAG_W-1:0] tag;
    logic [KEY_W-1:0] key;
    logic             last;
  } result_t;

  logic clk_i;
  logic rst_ni;

  smpq_req_if req_ch ();
  smpq_rsp_if rsp_ch ();

  stable_min_priority_queue_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch.sink),
    .rsp_o (rsp_ch.source)
  );

  // model state and bench bookkeeping
  entry_t      model_slots[$];
  result_t     expected_results[$];
  int unsigned error_count;
  int unsigned cycle_count;
  bit          req_idle_on;
  bit          rsp_idle_on;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // cycle counter and timeout
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // one line per mismatch
  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    error_count++;
    $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // model of the sorted slot list: push the results of one request
  function automatic void predict_request(req_e req, logic [TAG_W-1:0] tag,
                                          logic [KEY_W-1:0] key);
    result_t res;
    entry_t  ent;
    int      pos;
    res = '{status: STATUS_INSERTED, tag: '0, key: '0, last: 1'b1};
    case (req)
      REQ_INSERT: begin
        if (model_slots.size() >= QUEUE_DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          // stable: after every entry with key <= new key
          pos = 0;
          while (pos < model_slots.size() && model_slots[pos].key <= key) pos++;
          ent.tag = tag;
          ent.key = key;
          model_slots.insert(pos, ent);
        end
        expected_results.push_back(res);
      end
      REQ_POP: begin
        if (model_slots.size() == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          ent        = model_slots.pop_front();
          res.status = STATUS_POPPED;
          res.tag    = ent.tag;
          res.key    = ent.key;
        end
        expected_results.push_back(res);
      end
      REQ_LIST: begin
        if (model_slots.size() == 0) begin
          res.status = STATUS_EMPTY;
          expected_results.push_back(res);
        end else begin
          foreach (model_slots[i]) begin
            res.status = STATUS_LISTED;
            res.tag    = model_slots[i].tag;
            res.key    = model_slots[i].key;
            res.last   = (i == model_slots.size() - 1);
            expected_results.push_back(res);
          end
        end
      end
      default: ;  // unused code: no result, no change
    endcase
  endfunction

  // drive one request, wait for its handshake, then maybe idle
  task automatic send_request(req_e req, logic [TAG_W-1:0] tag, logic [KEY_W-1:0] key);
    int unsigned gap;
    @(negedge clk_i);
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= req;
    req_ch.entry_tag <= tag;
    req_ch.entry_key <= key;
    do @(posedge clk_i); while (!req_ch.ready);
    predict_request(req, tag, key);
    if (req_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_results_drained();
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // result sink: stall bursts mixed with free-running stretches
  initial begin
    int unsigned stall_left;
    int unsigned free_left;
    stall_left   = 0;
    free_left    = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (free_left > 0) begin
          free_left--;
        end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
          stall_left = $urandom_range(1, 7);
          free_left  = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 6);
        end
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("[%0t] unexpected result: status %0d tag 0x%0h key 0x%0h last %0b",
                 $time, rsp_ch.status, rsp_ch.out_tag, rsp_ch.out_key, rsp_ch.last);
      end else begin
        want = expected_results.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", rsp_ch.status, want.status);
        if (rsp_ch.out_tag !== want.tag)
          report_mismatch("out_tag", rsp_ch.out_tag, want.tag);
        if (rsp_ch.out_key !== want.key)
          report_mismatch("out_key", rsp_ch.out_key, want.key);
        if (rsp_ch.last !== want.last)
          report_mismatch("last", rsp_ch.last, want.last);
      end
    end
  end

  // pop and list on an empty queue, unused request code
  task automatic test_empty_queue();
    send_request(REQ_POP, 16'h0000, 16'h0000);
    send_request(REQ_LIST, 16'hFFFF, 16'hFFFF);
    send_request(REQ_NONE, 16'hA5A5, 16'h5A5A);
  endtask

  // extreme keys and tags, equal keys leave in arrival order
  task automatic test_stable_order();
    send_request(REQ_INSERT, 16'hFFFF, 16'hFFFF);
    send_request(REQ_INSERT, 16'h0000, 16'h0000);
    send_request(REQ_INSERT, 16'h000A, 16'h0005);
    send_request(REQ_INSERT, 16'h000B, 16'h0005);
    send_request(REQ_INSERT, 16'h000C, 16'h0005);
    send_request(REQ_LIST, 16'h0000, 16'h0000);
    send_request(REQ_POP, 16'h0000, 16'h0000);
    send_request(REQ_POP, 16'h0000, 16'h0000);
  endtask

  // fill to capacity, refused insert, full list
  task automatic test_full_queue();
    while (model_slots.size() < QUEUE_DEPTH)
      send_request(REQ_INSERT, 16'($urandom), 16'($urandom_range(0, 3)));
    send_request(REQ_INSERT, 16'h1234, 16'h0000);
    send_request(REQ_LIST, 16'h0000, 16'h0000);
  endtask

  // random request with a bias toward filling or draining
  task automatic send_random_request(bit filling);
    int unsigned pick;
    req_e        req;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(0, 99);
    if (pick < 3)
      req = REQ_NONE;
    else if (filling)
      req = (pick < 70) ? REQ_INSERT : (pick < 92) ? REQ_POP : REQ_LIST;
    else
      req = (pick < 28) ? REQ_INSERT : (pick < 86) ? REQ_POP : REQ_LIST;
    // narrow keys half the time so ties are common
    key = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
    send_request(req, 16'($urandom), key);
  endtask

  task automatic test_random_mix(int unsigned count);
    bit          filling;
    int unsigned phase_left;
    filling    = 1'b0;
    phase_left = 0;
    repeat (count) begin
      if (phase_left == 0) begin
        filling    = ~filling;
        phase_left = $urandom_range(8, 40);
      end
      phase_left--;
      send_random_request(filling);
    end
  endtask

  // sender holds off until every result is back, then carries on
  task automatic test_drain_pause();
    repeat (6) send_request(REQ_INSERT, 16'($urandom), 16'($urandom_range(0, 7)));
    send_request(REQ_LIST, 16'h0000, 16'h0000);
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    wait_results_drained();
    repeat (3) send_request(REQ_POP, 16'h0000, 16'h0000);
    send_request(REQ_LIST, 16'h0000, 16'h0000);
  endtask

  // closing stretch with no stalls on either side
  task automatic test_back_to_back();
    req_idle_on = 1'b0;
    rsp_idle_on = 1'b0;
    test_random_mix(50);
  endtask

  // main sequence
  initial begin
    error_count      = 0;
    req_idle_on      = 1'b1;
    rsp_idle_on      = 1'b1;
    rst_ni           = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_NONE;
    req_ch.entry_tag = '0;
    req_ch.entry_key = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_queue();
    test_stable_order();
    test_full_queue();
    test_random_mix(370);
    test_drain_pause();
    test_back_to_back();

    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
